// ----- hdl/npa_pkg.sv -----
package npa_pkg;

    localparam int PLATE_BITS     = 5;
    localparam int NUM_POLES_BITS = 5;
    localparam int INDEX_BITS     = 4;
    localparam int ADDR_BITS      = 3;
    localparam int DATA_BITS      = 32;

    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;

    // Register number, taken from the word address bit of paddr.
    localparam logic [0:0] REG_NUM_POLES = 1'b0;

    typedef struct packed {
        logic                  valid;
        logic                  mode;
        logic [INDEX_BITS-1:0] pole_index;
    } npa_ctl_t;

endpackage

// ----- hdl/npa_cell.sv -----
module npa_cell
    import npa_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int PNUM_W     = 5,
    parameter int INDEX      = 0
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           active,
    input  npa_ctl_t                       ctl_in,
    input  logic signed [COORD_BITS-1:0]   vx_in,
    input  logic signed [COORD_BITS-1:0]   vy_in,
    input  logic signed [COORD_BITS-1:0]   vz_in,
    input  logic signed [2*COORD_BITS:0]   best_in,
    input  logic        [PNUM_W-1:0]       plate_in,
    output npa_ctl_t                       ctl_out,
    output logic signed [COORD_BITS-1:0]   vx_out,
    output logic signed [COORD_BITS-1:0]   vy_out,
    output logic signed [COORD_BITS-1:0]   vz_out,
    output logic signed [2*COORD_BITS:0]   best_out,
    output logic        [PNUM_W-1:0]       plate_out
);

    localparam int PROD_W  = 2 * COORD_BITS;
    localparam int SCORE_W = PROD_W + 1;
    localparam logic [PNUM_W-1:0] PLATE_HERE = PNUM_W'(INDEX + 1);

    // Pole held by this cell.
    logic signed [COORD_BITS-1:0] pole_x_reg, pole_y_reg, pole_z_reg;

    // First stage: products.
    npa_ctl_t                     ctl1_reg;
    logic signed [COORD_BITS-1:0] vx1_reg, vy1_reg, vz1_reg;
    logic signed [SCORE_W-1:0]    best1_reg;
    logic        [PNUM_W-1:0]     plate1_reg;
    logic signed [PROD_W-1:0]     prod_x_reg, prod_y_reg, prod_z_reg;

    // Second stage: sum and compare.
    npa_ctl_t                     ctl2_reg;
    logic signed [COORD_BITS-1:0] vx2_reg, vy2_reg, vz2_reg;
    logic signed [SCORE_W-1:0]    best2_reg;
    logic        [PNUM_W-1:0]     plate2_reg;

    logic                         load_here;
    logic signed [SCORE_W-1:0]    dot;
    logic                         take;
    logic signed [SCORE_W-1:0]    best2_next;
    logic        [PNUM_W-1:0]     plate2_next;

    assign load_here = ctl_in.valid && (ctl_in.mode == MODE_LOAD)
                    && (32'(ctl_in.pole_index) == INDEX);

    assign dot = SCORE_W'(prod_x_reg) + SCORE_W'(prod_y_reg) + SCORE_W'(prod_z_reg);
    assign take = active && ctl1_reg.valid && (ctl1_reg.mode == MODE_CLASSIFY)
               && (dot > best1_reg);

    always_comb
    begin
        best2_next  = best1_reg;
        plate2_next = plate1_reg;
        if (take)
        begin
            best2_next  = dot;
            plate2_next = PLATE_HERE;
        end
    end

    // A load writes the pole as it enters, so the next beat already sees it.
    always_ff @(posedge clk)
    begin
        if (advance && load_here)
        begin
            pole_x_reg <= vx_in;
            pole_y_reg <= vy_in;
            pole_z_reg <= vz_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (advance)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vx1_reg    <= vx_in;
            vy1_reg    <= vy_in;
            vz1_reg    <= vz_in;
            best1_reg  <= best_in;
            plate1_reg <= plate_in;
            prod_x_reg <= vx_in * pole_x_reg;
            prod_y_reg <= vy_in * pole_y_reg;
            prod_z_reg <= vz_in * pole_z_reg;
            vx2_reg    <= vx1_reg;
            vy2_reg    <= vy1_reg;
            vz2_reg    <= vz1_reg;
            best2_reg  <= best2_next;
            plate2_reg <= plate2_next;
        end
    end

    assign ctl_out   = ctl2_reg;
    assign vx_out    = vx2_reg;
    assign vy_out    = vy2_reg;
    assign vz_out    = vz2_reg;
    assign best_out  = best2_reg;
    assign plate_out = plate2_reg;

endmodule

// ----- hdl/nearest_pole_assignment_unit.sv -----
// Channel   Direction  Handshake                    Beat contents
// item      in         item_valid / item_ready      mode, pole_index, vec_x, vec_y, vec_z
// result    out        result_valid / result_ready  plate_number, best_score
// config    in         APB (psel, penable, ...)     num_poles at byte address 0
//
// One item is taken per cycle while the result is not stalled; each pole cell is
// two register stages deep; a classify beat crosses all cells, then the result register.
// A load beat walks the same chain and writes its pole on reaching its cell.
// Reset clears the beat valid bits and sets num_poles to 1; the pole table is
// undefined until loaded.
// A stalled result freezes the whole chain, and item_ready follows it.
module nearest_pole_assignment_unit
    import npa_pkg::*;
#(
    parameter int MAX_POLES  = 16,
    parameter int COORD_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          mode,
    input  logic [INDEX_BITS-1:0]         pole_index,
    input  logic signed [COORD_BITS-1:0]  vec_x,
    input  logic signed [COORD_BITS-1:0]  vec_y,
    input  logic signed [COORD_BITS-1:0]  vec_z,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [PLATE_BITS-1:0]         plate_number,
    output logic signed [2*COORD_BITS:0]  best_score,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_BITS-1:0]          paddr,
    input  logic [DATA_BITS-1:0]          pwdata,
    output logic [DATA_BITS-1:0]          prdata,
    output logic                          pready
);

    localparam int PROD_W  = 2 * COORD_BITS;
    localparam int SCORE_W = PROD_W + 1;
    localparam int PNUM_W  = $clog2(MAX_POLES + 1);
    localparam int PL_W    = (PNUM_W > PLATE_BITS) ? PNUM_W : PLATE_BITS;
    localparam int CNT_W   = (PNUM_W > NUM_POLES_BITS) ? PNUM_W : NUM_POLES_BITS;
    localparam logic signed [SCORE_W-1:0] SCORE_START = {2'b11, {(PROD_W-1){1'b0}}};

    logic [NUM_POLES_BITS-1:0] num_poles_reg;
    logic [CNT_W-1:0]          num_ext;
    logic [CNT_W-1:0]          count_eff;
    logic [MAX_POLES-1:0]      active;
    logic                      advance;
    logic                      cfg_write;

    npa_ctl_t                     ctl_w   [0:MAX_POLES];
    logic signed [COORD_BITS-1:0] vx_w    [0:MAX_POLES];
    logic signed [COORD_BITS-1:0] vy_w    [0:MAX_POLES];
    logic signed [COORD_BITS-1:0] vz_w    [0:MAX_POLES];
    logic signed [SCORE_W-1:0]    best_w  [0:MAX_POLES];
    logic        [PNUM_W-1:0]     plate_w [0:MAX_POLES];

    logic                      result_valid_reg, result_valid_next;
    logic [PL_W-1:0]           plate_reg;
    logic signed [SCORE_W-1:0] score_reg;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[ADDR_BITS-1] == REG_NUM_POLES);
    assign prdata    = (paddr[ADDR_BITS-1] == REG_NUM_POLES)
                     ? DATA_BITS'(num_poles_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_poles_reg <= NUM_POLES_BITS'(1);
        end
        else if (cfg_write)
        begin
            num_poles_reg <= pwdata[NUM_POLES_BITS-1:0];
        end
    end

    // Zero searches one pole; anything past the table stops at its end.
    assign num_ext = CNT_W'(num_poles_reg);
    always_comb
    begin
        if (num_ext == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (num_ext > CNT_W'(MAX_POLES))
        begin
            count_eff = CNT_W'(MAX_POLES);
        end
        else
        begin
            count_eff = num_ext;
        end
    end

    assign advance    = !result_valid_reg || result_ready;
    assign item_ready = advance;

    assign ctl_w[0].valid      = item_valid;
    assign ctl_w[0].mode       = mode;
    assign ctl_w[0].pole_index = pole_index;
    assign vx_w[0]             = vec_x;
    assign vy_w[0]             = vec_y;
    assign vz_w[0]             = vec_z;
    assign best_w[0]           = SCORE_START;
    assign plate_w[0]          = PNUM_W'(1);

    genvar p;
    generate
        for (p = 0; p < MAX_POLES; p++)
        begin : g_cell
            assign active[p] = CNT_W'(p) < count_eff;

            npa_cell #(
                .COORD_BITS (COORD_BITS),
                .PNUM_W     (PNUM_W),
                .INDEX      (p)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .active    (active[p]),
                .ctl_in    (ctl_w[p]),
                .vx_in     (vx_w[p]),
                .vy_in     (vy_w[p]),
                .vz_in     (vz_w[p]),
                .best_in   (best_w[p]),
                .plate_in  (plate_w[p]),
                .ctl_out   (ctl_w[p+1]),
                .vx_out    (vx_w[p+1]),
                .vy_out    (vy_w[p+1]),
                .vz_out    (vz_w[p+1]),
                .best_out  (best_w[p+1]),
                .plate_out (plate_w[p+1])
            );
        end
    endgenerate

    // Load beats end at the last cell; only classify beats become results.
    assign result_valid_next = ctl_w[MAX_POLES].valid
                            && (ctl_w[MAX_POLES].mode == MODE_CLASSIFY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            plate_reg <= PL_W'(plate_w[MAX_POLES]);
            score_reg <= best_w[MAX_POLES];
        end
    end

    assign result_valid = result_valid_reg;
    assign plate_number = plate_reg[PLATE_BITS-1:0];
    assign best_score   = score_reg;

    a_plate_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (plate_reg != '0))
        else $error("result carries plate index zero");

    a_score_floor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (score_reg >= SCORE_START))
        else $error("result score below search start");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(result_valid_next))
        else $error("result appeared without a classify beat at chain end");

endmodule
